// ----- rtl/biou_pkg.sv -----
// Package with the transaction types and constants of the box IoU matrix.
`timescale 1ns / 1ps
`default_nettype none
package biou_pkg;

  localparam int FieldBits   = 12;
  localparam int SlotBits    = 6;
  localparam int CountBits   = 7;
  localparam int FracBits    = 16;
  localparam int QuoBits     = FracBits + 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [SlotBits-1:0]  ref_slot;
    logic [FieldBits-1:0] box_x;
    logic [FieldBits-1:0] box_y;
    logic [FieldBits-1:0] box_w;
    logic [FieldBits-1:0] box_h;
  } biou_in_t;

  typedef struct packed {
    logic [QuoBits-1:0]  iou_q16;
    logic [SlotBits-1:0] ref_index;
    logic                overlaps;
    logic                last;
  } biou_out_t;

endpackage
`default_nettype wire

// ----- rtl/biou_if.sv -----
// Valid/ready stream interfaces for the input and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface biou_in_if;
  import biou_pkg::*;
  logic     valid;
  logic     ready;
  biou_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface biou_out_if;
  import biou_pkg::*;
  logic      valid;
  logic      ready;
  biou_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/biou_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module biou_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/biou_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit and passes on.
`timescale 1ns / 1ps
`default_nettype none
module biou_div_cell #(
  parameter int DivBits = 25,
  parameter int QBits   = 17,
  localparam int RemBits = DivBits + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [RemBits-1:0] rem_i,
  input  wire logic [DivBits-1:0] div_i,
  input  wire logic [QBits-1:0]   quo_i,
  output logic                    valid_o,
  output logic      [RemBits-1:0] rem_o,
  output logic      [DivBits-1:0] div_o,
  output logic      [QBits-1:0]   quo_o
);

  logic               bit_w;
  logic [RemBits-1:0] diff_w;

  assign bit_w  = rem_i >= {1'b0, div_i};
  assign diff_w = bit_w ? (rem_i - {1'b0, div_i}) : rem_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o <= {diff_w[RemBits-2:0], 1'b0};
    div_o <= div_i;
    quo_o <= {quo_i[QBits-2:0], bit_w};
  end

endmodule
`default_nettype wire

// ----- rtl/box_iou_matrix.sv -----
// Top level of the box intersection-over-union matrix.
`timescale 1ns / 1ps
`default_nettype none
// Load transactions write one reference box into a table of MAX_REFS entries;
// a load whose slot is not below MAX_REFS is dropped. A query transaction is
// compared against references 0 up to min(ref_count, MAX_REFS) - 1 in order
// and yields one result each, the final one flagged by last. Each result goes
// through a table read, the multiplies, the union, then a chain of division
// cells that resolves one quotient bit per cell, and a hand-over to the output
// register. A query occupies the block until its final result has been handed
// over, also while the output register is still full, and no new transaction
// is accepted during that time.
// The result is zero whenever the boxes do not overlap.
module box_iou_matrix
  import biou_pkg::*;
#(
  parameter int MAX_REFS   = 64,
  parameter int COORD_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CountBits-1:0] cfg_data_i,
  biou_in_if.sink                   in_i,
  biou_out_if.source                out_o
);

  localparam int C        = COORD_BITS;
  localparam int AddrBits = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int KBits    = $clog2(MAX_REFS + 1);
  localparam int EBits    = C + 2;
  localparam int PBits    = 2 * C;
  localparam int UBits    = 2 * C + 1;
  localparam int RBits    = UBits + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_GEOM  = 3'd2;
  localparam logic [2:0] ST_UNION = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CountBits-1:0] ref_count_q;
  logic [KBits-1:0]     k_q, k_d;
  logic [KBits-1:0]     count_q, count_d;
  logic [4*C-1:0]       qbox_q;
  logic [4*C-1:0]       in_box_w;
  logic [4*C-1:0]       rbox_w;
  logic [PBits-1:0]     inter_q, qarea_q, rarea_q;
  logic                 ovl_q;
  logic [QuoBits-1:0]   quo_q;
  logic                 out_valid_q;
  biou_out_t            out_data_q;

  logic                 ram_we_w;
  logic [KBits-1:0]     count_w;
  logic                 last_w;

  logic [RBits-1:0]     rem_w  [QuoBits+1];
  logic [UBits-1:0]     div_w  [QuoBits+1];
  logic [QuoBits-1:0]   quo_w  [QuoBits+1];
  logic                 vld_w  [QuoBits+1];

  assign in_box_w = {C'(in_i.data.box_x), C'(in_i.data.box_y),
                     C'(in_i.data.box_w), C'(in_i.data.box_h)};
  assign in_i.ready = (state_q == ST_IDLE);
  assign ram_we_w = in_i.valid && in_i.ready && (in_i.data.opcode == OP_LOAD) &&
                    (32'(in_i.data.ref_slot) < MAX_REFS);
  assign count_w = (32'(ref_count_q) > MAX_REFS) ? KBits'(MAX_REFS)
                                                 : KBits'(ref_count_q);
  assign last_w = ((k_q + 1'b1) == count_q);

  biou_ram #(
    .Width (4 * C),
    .Depth (MAX_REFS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we_w),
    .waddr_i (AddrBits'(in_i.data.ref_slot)),
    .wdata_i (in_box_w),
    .raddr_i (AddrBits'(k_q)),
    .rdata_o (rbox_w)
  );

  // Intersection extents and areas from the query box and the table entry.
  logic [C-1:0]     qx, qy, qw, qh, rx, ry, rw, rh;
  logic [EBits-1:0] q_right, r_right, q_bot, r_bot, left, top, iw_s, ih_s;
  logic             ovl_w;
  logic [C-1:0]     iw_w, ih_w;

  always_comb begin
    {qx, qy, qw, qh} = qbox_q;
    {rx, ry, rw, rh} = rbox_w;
    q_right = EBits'(qx) + EBits'(qw);
    r_right = EBits'(rx) + EBits'(rw);
    q_bot   = EBits'(qy) + EBits'(qh);
    r_bot   = EBits'(ry) + EBits'(rh);
    left    = (qx > rx) ? EBits'(qx) : EBits'(rx);
    top     = (qy > ry) ? EBits'(qy) : EBits'(ry);
    iw_s    = ((q_right < r_right) ? q_right : r_right) - left;
    ih_s    = ((q_bot < r_bot) ? q_bot : r_bot) - top;
    ovl_w   = !iw_s[EBits-1] && (iw_s != '0) && !ih_s[EBits-1] && (ih_s != '0);
    iw_w    = ovl_w ? iw_s[C-1:0] : '0;
    ih_w    = ovl_w ? ih_s[C-1:0] : '0;
  end

  assign vld_w[0] = (state_q == ST_UNION);
  assign rem_w[0] = RBits'(inter_q);
  assign div_w[0] = UBits'(qarea_q) + UBits'(rarea_q) - UBits'(inter_q);
  assign quo_w[0] = '0;

  for (genvar i = 0; i < QuoBits; i++) begin : g_cell
    biou_div_cell #(
      .DivBits (UBits),
      .QBits   (QuoBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[i]),
      .rem_i   (rem_w[i]),
      .div_i   (div_w[i]),
      .quo_i   (quo_w[i]),
      .valid_o (vld_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .div_o   (div_w[i+1]),
      .quo_o   (quo_w[i+1])
    );
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && (in_i.data.opcode == OP_QUERY) && (count_w != '0)) begin
          k_d     = '0;
          count_d = count_w;
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_GEOM;
      ST_GEOM:  state_d = ST_UNION;
      ST_UNION: state_d = ST_DIV;
      ST_DIV: begin
        if (vld_w[QuoBits]) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          if (last_w) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_count_q <= CountBits'(1);
      k_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        ref_count_q <= cfg_data_i;
      end
      if ((state_q == ST_EMIT) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      qbox_q <= in_box_w;
    end
    if (state_q == ST_GEOM) begin
      inter_q <= iw_w * ih_w;
      qarea_q <= qw * qh;
      rarea_q <= rw * rh;
      ovl_q   <= ovl_w;
    end
    if ((state_q == ST_DIV) && vld_w[QuoBits]) begin
      quo_q <= quo_w[QuoBits];
    end
    if ((state_q == ST_EMIT) && (!out_valid_q || out_o.ready)) begin
      out_data_q.iou_q16   <= ovl_q ? quo_q : '0;
      out_data_q.ref_index <= SlotBits'(k_q);
      out_data_q.overlaps  <= ovl_q;
      out_data_q.last      <= last_w;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
`default_nettype wire
